/* rtl/ttcs_pkg.sv */
// Shared constants and types for the text terminal with cursor and scroll.
// Used by ttcs_screen_mem, ttcs_ctrl and text_terminal_cursor_scroll.
`default_nettype none

package ttcs_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int CLR_W  = 4;

    // Cell constants
    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;
    localparam logic [7:0]        BLANK_CHAR   = 8'h20;
    localparam logic [7:0]        NEWLINE_CHAR = 8'h0A;

    // Item function codes
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic REG_BG_COLOR   = 1'b1;

    // One access to the screen store
    typedef struct packed {
        logic              we;
        logic [POS_W-1:0]  waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [POS_W-1:0]  raddr;
    } mem_req_t;

endpackage : ttcs_pkg

`default_nettype wire

/* rtl/ttcs_screen_mem.sv */
// Screen store: CELL_COUNT x 16-bit cells, one write and one read per cycle,
// read data registered. Depends on ttcs_pkg.
`default_nettype none

module ttcs_screen_mem
    import ttcs_pkg::*;
(
    input  wire logic              aclk,
    input  wire mem_req_t          req,
    output logic      [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] cells [CELL_COUNT];

    // Write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            cells[req.waddr] <= req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata <= cells[req.raddr];
        end
    end

endmodule : ttcs_screen_mem

`default_nettype wire

/* rtl/ttcs_ctrl.sv */
// Item sequencer: cursor registers, store sweeps (clear, scroll, reset fill)
// and the result register. Depends on ttcs_pkg; drives ttcs_screen_mem.
`default_nettype none

module ttcs_ctrl
    import ttcs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // item in
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_func,
    input  wire logic [7:0]        in_ch,
    input  wire logic [POS_W-1:0]  in_index,
    // current attribute byte
    input  wire logic [7:0]        attr,
    // screen store
    output mem_req_t               mem_req,
    input  wire logic [CELL_W-1:0] mem_rdata,
    // result out
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [POS_W-1:0]  out_pos,
    output logic      [CELL_W-1:0] out_value,
    output logic                   out_scrolled
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FILL   = 3'd5;

    localparam logic [POS_W-1:0] CELL_LAST    = POS_W'(CELL_COUNT - 1);
    localparam logic [POS_W-1:0] MOVE_LAST    = POS_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [POS_W-1:0] BOTTOM_START = POS_W'(CELL_COUNT - COLUMNS);
    localparam logic [POS_W-1:0] COLS_POS     = POS_W'(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST     = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST     = ROW_W'(ROWS - 1);

    logic [2:0]        state_reg, state_next;
    logic              pend_reg, pend_next;
    logic              boot_reg, boot_next;
    logic              mv_valid_reg, mv_valid_next;
    logic [POS_W-1:0]  mv_addr_reg, mv_addr_next;
    logic [POS_W-1:0]  cnt_reg, cnt_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CELL_W-1:0] res_val_reg, res_val_next;
    logic              res_scr_reg, res_scr_next;
    logic              oval_reg, oval_next;
    logic [POS_W-1:0]  opos_reg, opos_next;
    logic [CELL_W-1:0] oval_data_reg, oval_data_next;
    logic              oscr_reg, oscr_next;
    logic [1:0]        func_reg;
    logic [7:0]        ch_reg;
    logic [POS_W-1:0]  idx_reg;

    logic              out_free;
    logic              accept;
    logic              is_nl;
    logic              is_print;
    logic [CELL_W-1:0] blank_cell;

    assign out_free   = !oval_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE) && (!pend_reg || out_free);
    assign accept     = in_valid && in_ready;
    assign is_nl      = (ch_reg == NEWLINE_CHAR);
    assign is_print   = !ch_reg[7] && (ch_reg[6:5] != 2'b00);
    assign blank_cell = {attr, BLANK_CHAR};

    assign out_valid    = oval_reg;
    assign out_pos      = opos_reg;
    assign out_value    = oval_data_reg;
    assign out_scrolled = oscr_reg;

    // Item payload capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= in_func;
            ch_reg   <= in_ch;
            idx_reg  <= in_index;
        end
    end

    // Sequencer and store access
    always_comb begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        boot_next      = boot_reg;
        mv_valid_next  = 1'b0;
        mv_addr_next   = mv_addr_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        res_val_next   = res_val_reg;
        res_scr_next   = res_scr_reg;
        oval_next      = oval_reg;
        opos_next      = opos_reg;
        oval_data_next = oval_data_reg;
        oscr_next      = oscr_reg;

        mem_req       = '0;
        mem_req.raddr = cnt_reg + COLS_POS;

        // result register drains independently
        if (out_ready) begin
            oval_next = 1'b0;
        end

        // pending move write from the scroll read stream
        if (mv_valid_reg) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = mv_addr_reg;
            mem_req.wdata = mem_rdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (pend_reg && out_free) begin
                    oval_next      = 1'b1;
                    opos_next      = pos_reg;
                    oval_data_next = res_val_reg;
                    oscr_next      = res_scr_reg;
                    pend_next      = 1'b0;
                end
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                res_val_next = '0;
                res_scr_next = 1'b0;
                pend_next    = 1'b1;
                state_next   = ST_IDLE;
                unique case (func_reg)
                    FUNC_PUT: begin
                        if (is_print) begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = pos_reg;
                            mem_req.wdata = {attr, ch_reg};
                        end
                        if (is_nl) begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                            pos_next = pos_reg - POS_W'(col_reg) + COLS_POS;
                        end else if (is_print) begin
                            pos_next = pos_reg + 1'b1;
                            if (col_reg == COL_LAST) begin
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                            end else begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        // row runs off the bottom: scroll
                        if ((is_nl || (is_print && col_reg == COL_LAST)) &&
                            row_reg == ROW_LAST) begin
                            row_next     = ROW_LAST;
                            col_next     = '0;
                            pos_next     = BOTTOM_START;
                            res_scr_next = 1'b1;
                            pend_next    = 1'b0;
                            cnt_next     = '0;
                            state_next   = ST_SCROLL;
                        end
                    end
                    FUNC_READ: begin
                        if (idx_reg <= CELL_LAST) begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = idx_reg;
                            pend_next     = 1'b0;
                            state_next    = ST_RDWAIT;
                        end
                    end
                    FUNC_CLEAR: begin
                        pend_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end
                    default: begin
                    end
                endcase
            end

            ST_RDWAIT: begin
                res_val_next = mem_rdata;
                pend_next    = 1'b1;
                state_next   = ST_IDLE;
            end

            // read row below, write it one row up on the next cycle
            ST_SCROLL: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cnt_reg + COLS_POS;
                mv_valid_next = 1'b1;
                mv_addr_next  = cnt_reg;
                if (cnt_reg == MOVE_LAST) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_DRAIN: begin
                cnt_next   = BOTTOM_START;
                state_next = ST_FILL;
            end

            // blank sweep from cnt to the last cell
            ST_FILL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg;
                mem_req.wdata = boot_reg ? RESET_CELL : blank_cell;
                if (cnt_reg == CELL_LAST) begin
                    pend_next  = !boot_reg;
                    boot_next  = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state; reset starts the store fill pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            pend_reg     <= 1'b0;
            boot_reg     <= 1'b1;
            mv_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            pos_reg      <= '0;
            oval_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            boot_reg     <= boot_next;
            mv_valid_reg <= mv_valid_next;
            cnt_reg      <= cnt_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pos_reg      <= pos_next;
            oval_reg     <= oval_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mv_addr_reg   <= mv_addr_next;
        res_val_reg   <= res_val_next;
        res_scr_reg   <= res_scr_next;
        opos_reg      <= opos_next;
        oval_data_reg <= oval_data_next;
        oscr_reg      <= oscr_next;
    end

`ifndef SYNTH
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_reg <= ROW_LAST) && (col_reg <= COL_LAST))
        else $error("cursor outside the screen");

    a_pos_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) == 32'(row_reg) * 32'(COLUMNS) + 32'(col_reg))
        else $error("linear cursor position out of step with row and column");

    a_move_in_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_valid_reg |-> (state_reg == ST_SCROLL || state_reg == ST_DRAIN))
        else $error("move write outside a scroll");

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("item taken while busy");

    a_no_result_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && !out_free) |=> pend_reg)
        else $error("pending result dropped");
`endif

endmodule : ttcs_ctrl

`default_nettype wire

/* rtl/text_terminal_cursor_scroll.sv */
// Top level of the text terminal: stream ports, color registers and the
// screen store. Depends on ttcs_pkg, ttcs_screen_mem and ttcs_ctrl.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: func, ch, cell_index
//  m_      | out | m_tvalid/m_tready  | m_tdata: cursor_pos, cell_value, scrolled
//  cfg_    | in  | cfg_wr_en          | cfg_addr, cfg_wdata
//
// Put character without a scroll, unused codes and an out-of-range read return to
// idle from ST_EXEC; an in-range read cell also passes ST_RDWAIT for the registered store read.
// Clear screen sweeps the store one cell a cycle.
// A scroll moves one cell a cycle and then blanks the bottom row.
// After reset a fill pass writes every cell (2000 here);
// no item is taken meanwhile. A stalled result holds until taken.
`default_nettype none

module text_terminal_cursor_scroll
    import ttcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // item beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // func[1:0], ch[9:2], cell_index[20:10], zero
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // cursor_pos[10:0], cell_value[26:11],
                                        // scrolled[27], zero
    // register writes
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [CLR_W-1:0] cfg_wdata
);

    logic [CLR_W-1:0]  text_color_reg;
    logic [CLR_W-1:0]  bg_color_reg;
    mem_req_t          mem_req;
    logic [CELL_W-1:0] mem_rdata;
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;

    // Color registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= CLR_W'(7);
            bg_color_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_TEXT_COLOR: text_color_reg <= cfg_wdata;
                REG_BG_COLOR:   bg_color_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ttcs_screen_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    ttcs_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_func      (s_tdata[1:0]),
        .in_ch        (s_tdata[9:2]),
        .in_index     (s_tdata[20:10]),
        .attr         ({bg_color_reg, text_color_reg}),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_pos      (cursor_pos),
        .out_value    (cell_value),
        .out_scrolled (scrolled)
    );

    // Result packing
    assign m_tdata = {4'b0000, scrolled, cell_value, cursor_pos};

endmodule : text_terminal_cursor_scroll

`default_nettype wire

/* test/text_terminal_cursor_scroll_tb.sv */
// Self-checking testbench for text_terminal_cursor_scroll: puts characters, reads cells and
// clears the screen under random color settings, predicting each status beat in a shadow screen.
// Depends on ttcs_pkg and the RTL of text_terminal_cursor_scroll.
`default_nettype none

module text_terminal_cursor_scroll_tb;
    import ttcs_pkg::*;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         SETTLE_CYCLES  = 50;
    localparam int         PRINT_CAP      = 40;

    typedef struct packed {
        logic [1:0]       func;
        logic [7:0]       ch;
        logic [POS_W-1:0] cell_index;
    } term_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } term_status_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = REG_TEXT_COLOR;
    logic [CLR_W-1:0] cfg_wdata = '0;

    text_terminal_cursor_scroll dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the terminal
    logic [CELL_W-1:0] shadow_screen [0:CELL_COUNT-1];
    int                shadow_col;
    int                shadow_row;
    logic [CLR_W-1:0]  fg_color;
    logic [CLR_W-1:0]  bg_color;

    term_cmd_t    pending_cmds[$];
    term_status_t expected_status[$];
    term_cmd_t    offered;

    int unsigned cmds_made      = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned tx_pause       = 0;
    int unsigned rx_stall       = 0;
    int unsigned hold_asked     = 0;
    int unsigned holds_served   = 0;
    bit          tx_calm        = 1'b0;
    bit          rx_calm        = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [CELL_W-1:0] paint(input logic [7:0] ch);
        return {bg_color, fg_color, ch};
    endfunction

    // Apply one command to the shadow terminal and return the status it yields
    function automatic term_status_t terminal_step(input term_cmd_t cmd);
        term_status_t st;
        int           k;
        st = '0;
        case (cmd.func)
            FUNC_PUT: begin
                if (cmd.ch == NEWLINE_CHAR) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (cmd.ch >= BLANK_CHAR && cmd.ch <= 8'h7F) begin
                    shadow_screen[shadow_row * COLUMNS + shadow_col] = paint(cmd.ch);
                    shadow_col++;
                end
                if (shadow_col >= COLUMNS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                // past the last row: move everything up and blank the bottom row
                if (shadow_row >= ROWS) begin
                    for (k = 0; k < CELL_COUNT - COLUMNS; k++)
                        shadow_screen[k] = shadow_screen[k + COLUMNS];
                    for (k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++)
                        shadow_screen[k] = paint(BLANK_CHAR);
                    shadow_row  = ROWS - 1;
                    shadow_col  = 0;
                    st.scrolled = 1'b1;
                end
            end
            FUNC_READ: begin
                if (cmd.cell_index < CELL_COUNT)
                    st.cell_value = shadow_screen[cmd.cell_index];
            end
            FUNC_CLEAR: begin
                for (k = 0; k < CELL_COUNT; k++)
                    shadow_screen[k] = paint(BLANK_CHAR);
            end
            default: ;
        endcase
        st.cursor_pos = POS_W'(shadow_row * COLUMNS + shadow_col);
        return st;
    endfunction

    // Pause length: mostly none or short, now and then long
    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch on %s at status beat %0d: got %h, want %h",
                     what, results_seen, got, want);
        mismatch_count++;
    endtask

    // Input driver: one beat at a time from pending_cmds
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_pause <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_status.push_back(terminal_step(offered));
            if (s_tvalid && !s_tready) begin
                // beat still waiting
            end else if (tx_pause != 0) begin
                s_tvalid <= 1'b0;
                tx_pause <= tx_pause - 1;
            end else if (pending_cmds.size() != 0) begin
                offered  = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, offered.cell_index, offered.ch, offered.func};
                tx_pause <= tx_calm ? 0 : pick_pause();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side ready: random stalls plus requested long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            rx_stall     <= 0;
            holds_served <= 0;
        end else if (rx_stall != 0) begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else if (holds_served != hold_asked) begin
            m_tready     <= 1'b0;
            rx_stall     <= HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
        end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                   : $urandom_range(9, 49);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Status monitor: m_tdata = cursor_pos[10:0], cell_value[26:11], scrolled[27]
    always @(posedge aclk) begin
        term_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_status.size() == 0) begin
                note_mismatch("status beat with nothing expected", m_tdata, '0);
            end else begin
                want = expected_status.pop_front();
                if (m_tdata[10:0] !== want.cursor_pos)
                    note_mismatch("cursor_pos", 32'(m_tdata[10:0]), 32'(want.cursor_pos));
                if (m_tdata[26:11] !== want.cell_value)
                    note_mismatch("cell_value", 32'(m_tdata[26:11]), 32'(want.cell_value));
                if (m_tdata[27] !== want.scrolled)
                    note_mismatch("scrolled", 32'(m_tdata[27]), 32'(want.scrolled));
            end
            results_seen++;
        end
    end

    // Watchdog on cycles without any beat or register write
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_cmd(input logic [1:0] func, input logic [7:0] ch,
                            input logic [POS_W-1:0] idx);
        term_cmd_t c;
        c.func       = func;
        c.ch         = ch;
        c.cell_index = idx;
        pending_cmds.push_back(c);
        cmds_made++;
    endtask

    task automatic push_put(input logic [7:0] ch);
        push_cmd(FUNC_PUT, ch, POS_W'($urandom_range(0, 2047)));
    endtask

    task automatic push_read(input logic [POS_W-1:0] idx);
        push_cmd(FUNC_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    function automatic logic [POS_W-1:0] pick_cell();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return POS_W'($urandom_range(0, 2047));
        else if (r < 7)
            return POS_W'($urandom_range(CELL_COUNT - COLUMNS, CELL_COUNT - 1));
        else if (r < 8)
            return POS_W'($urandom_range(0, COLUMNS));
        return POS_W'($urandom_range(CELL_COUNT - 5, 2047));
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(BLANK_CHAR, 8'h7F));
    endfunction

    // Wait until everything sent has been taken and answered
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_colors(input logic [CLR_W-1:0] fg, input logic [CLR_W-1:0] bg);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_TEXT_COLOR;
        cfg_wdata <= fg;
        @(posedge aclk);
        cfg_addr  <= REG_BG_COLOR;
        cfg_wdata <= bg;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fg_color = fg;
        bg_color = bg;
    endtask

    // Random traffic built mostly from lines of text
    task automatic add_random_traffic(input int unsigned count);
        int unsigned goal;
        int unsigned pick;
        int unsigned sub;
        goal = cmds_made + count;
        while (cmds_made < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // a line, with a few reads and stray bytes mixed in
                repeat ($urandom_range(0, 24)) begin
                    sub = $urandom_range(0, 19);
                    if (sub < 16)
                        push_put(printable());
                    else if (sub < 18)
                        push_read(pick_cell());
                    else if (sub == 18)
                        push_put(8'($urandom_range(0, 8'h1F)));
                    else
                        push_put(8'($urandom_range(8'h80, 8'hFF)));
                end
                if ($urandom_range(0, 9) != 0)
                    push_put(NEWLINE_CHAR);
            end else if (pick < 56) begin
                // long run that wraps at the row end
                repeat ($urandom_range(COLUMNS, 170))
                    push_put(printable());
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 8))
                    push_read(pick_cell());
            end else if (pick < 95) begin
                // noise: any code with any field values
                repeat ($urandom_range(1, 6))
                    push_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             POS_W'($urandom_range(0, 2047)));
            end else if (pick < 98) begin
                push_cmd(FUNC_CLEAR, 8'($urandom_range(0, 255)),
                         POS_W'($urandom_range(0, 2047)));
            end else begin
                push_cmd(FUNC_UNUSED, 8'($urandom_range(0, 255)),
                         POS_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    // Stimulus and end of run
    initial begin
        for (int k = 0; k < CELL_COUNT; k++)
            shadow_screen[k] = RESET_CELL;
        shadow_col = 0;
        shadow_row = 0;
        fg_color   = 4'd7;
        bg_color   = 4'd0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: byte classes, cell range edges, unused code, clear
        push_cmd(FUNC_PUT, 8'h48, 11'h7FF);
        push_cmd(FUNC_PUT, BLANK_CHAR, 11'h000);
        push_put(8'h7F);
        push_put(8'h00);
        push_put(8'h1F);
        push_put(8'h80);
        push_put(8'hFF);
        push_put(8'h41);
        push_put(NEWLINE_CHAR);
        push_put(8'h5A);
        push_cmd(FUNC_READ, 8'hFF, 11'd0);
        push_read(11'd2);
        push_read(11'd3);
        push_read(POS_W'(COLUMNS));
        push_read(POS_W'(CELL_COUNT - 1));
        push_read(POS_W'(CELL_COUNT));
        push_cmd(FUNC_READ, 8'h00, 11'h7FF);
        push_cmd(FUNC_UNUSED, 8'hFF, 11'h7FF);
        push_cmd(FUNC_UNUSED, 8'h00, 11'h000);
        push_cmd(FUNC_CLEAR, 8'h00, 11'h000);
        push_read(11'd0);
        push_read(POS_W'(CELL_COUNT - 1));

        set_colors(4'd15, 4'd15);
        add_random_traffic(255);

        // receiver holds off while the sender streams without gaps
        set_colors(4'd0, 4'd0);
        tx_calm = 1'b1;
        hold_asked++;
        add_random_traffic(255);

        set_colors(4'd15, 4'd0);
        rx_calm = 1'b1;
        add_random_traffic(255);

        // sender stops halfway until every status beat is back
        set_colors(4'd0, 4'd15);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        add_random_traffic(130);
        wait_idle();
        add_random_traffic(125);

        set_colors(CLR_W'($urandom_range(0, 15)), CLR_W'($urandom_range(0, 15)));
        add_random_traffic(255);

        set_colors(CLR_W'($urandom_range(0, 15)), CLR_W'($urandom_range(0, 15)));
        tx_calm = 1'($urandom_range(0, 1));
        add_random_traffic(255);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule : text_terminal_cursor_scroll_tb

`default_nettype wire
